// File: hdl/llp_pkg.sv
// Shared types, constants and a helper function for the looper layer playback block.
package llp_pkg;

   localparam int LOOP_DEPTH  = 65536;
   localparam int LAYER_COUNT = 8;
   localparam int SAMPLE_BITS = 24;

   localparam int POS_BITS   = 16;
   localparam int LAYER_BITS = 3;
   localparam int ADDR_BITS  = LAYER_BITS + POS_BITS;
   localparam int LEN_BITS   = 17;
   localparam int FADE_BITS  = 16;
   localparam int SPEED_BITS = 11;
   localparam int MIX_BITS   = SAMPLE_BITS + LAYER_BITS;
   localparam int OUT_BITS   = 27;
   localparam int PROD_BITS  = MIX_BITS + FADE_BITS + 1;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 17;

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_PLAY_STATE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOOP_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CROSSFADE_LEN = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPEED         = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REVERSED      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAYER_ACTIVE  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECORD_LAYER  = 3'd6;

   // Transaction modes.
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_LOAD   = 2'd1;
   localparam logic [1:0] MODE_SEEK   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Play states.
   localparam logic [1:0] PS_EMPTY  = 2'd0;
   localparam logic [1:0] PS_PLAY   = 2'd1;
   localparam logic [1:0] PS_MUTED  = 2'd2;
   localparam logic [1:0] PS_RECORD = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;       // latch transaction and compute read position
      logic mem_read;    // issue read of the current layer
      logic acc;         // add returned read data into the mix
      logic rec_read;    // read the record layer
      logic rec_write;   // write back the overdub sum
      logic load_write;  // load write into the store
      logic seek;        // apply seek
      logic fade_start;  // start the fade multiply and divide
      logic div_step;    // one divider step
      logic mod_start;   // start the pointer wrap modulo the loop length
      logic mod_step;    // one modulo step
      logic finish;      // select the result, advance pointer, present result
   } llp_cmd_type;

   typedef struct packed {
      logic [LAYER_BITS-1:0] layer;
   } llp_cmd_arg_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic                  tick_live;   // tick in playing or recording state
      logic                  pos_valid;   // pointer inside the loop
      logic                  recording;   // recording state, overdub into the record layer
      logic                  fade_needed; // read position inside a fade zone
      logic                  is_load;
      logic                  is_seek;
      logic [LAYER_COUNT-1:0] active;
   } llp_status_type;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [SAMPLE_BITS+1:0] v);
      logic signed [SAMPLE_BITS+1:0] hi;
      logic signed [SAMPLE_BITS+1:0] lo;
      hi = (SAMPLE_BITS+2)'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
      lo = -hi - 1;
      if (v > hi) return hi[SAMPLE_BITS-1:0];
      if (v < lo) return lo[SAMPLE_BITS-1:0];
      return v[SAMPLE_BITS-1:0];
   endfunction

endpackage

// File: hdl/llp_if.sv
// Valid/ready channel interfaces for the request and response transactions.
interface llp_req_if import llp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic [LAYER_BITS-1:0]         layer_index;
   logic [POS_BITS-1:0]           position;
   modport source (output valid, mode, sample_in, layer_index, position, input ready);
   modport sink (input valid, mode, sample_in, layer_index, position, output ready);
endinterface

interface llp_rsp_if import llp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] sample_out;
   logic [POS_BITS-1:0]        play_position;
   modport source (output valid, sample_out, play_position, input ready);
   modport sink (input valid, sample_out, play_position, output ready);
endinterface

// File: hdl/llp_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
module llp_ctrl import llp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            rsp_busy,
   input  llp_status_type  status,
   output llp_cmd_type     cmd,
   output llp_cmd_arg_type arg
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECIDE = 4'd1;
   localparam logic [3:0] ST_READ   = 4'd2;
   localparam logic [3:0] ST_ACC    = 4'd3;
   localparam logic [3:0] ST_RREAD  = 4'd4;
   localparam logic [3:0] ST_RWAIT  = 4'd5;
   localparam logic [3:0] ST_RWRITE = 4'd6;
   localparam logic [3:0] ST_FADE   = 4'd7;
   localparam logic [3:0] ST_DIV    = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;
   localparam logic [3:0] ST_LOAD   = 4'd10;
   localparam logic [3:0] ST_MOD    = 4'd11;
   localparam logic [3:0] ST_MSTEP  = 4'd12;
   localparam logic [3:0] ST_SEEK   = 4'd13;

   localparam int DIV_STEPS = PROD_BITS;
   localparam int MOD_STEPS = LEN_BITS;
   localparam int CNT_BITS = $clog2(DIV_STEPS + 1);

   logic [3:0]            state_ff, state_in;
   logic [LAYER_BITS-1:0] layer_ff, layer_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_busy;
   assign arg.layer = layer_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      count_in = count_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.start = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            layer_in = '0;
            if (status.is_load) begin
               state_in = ST_LOAD;
            end else if (status.is_seek) begin
               state_in = ST_MOD;
            end else if (status.tick_live && status.pos_valid) begin
               state_in = ST_READ;
            end else if (status.tick_live) begin
               state_in = ST_MOD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = status.active[layer_ff];
            if (layer_ff == LAYER_BITS'(LAYER_COUNT - 1)) begin
               state_in = status.recording ? ST_RREAD : ST_FADE;
            end else begin
               layer_in = layer_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_RREAD: begin
            cmd.rec_read = 1'b1;
            state_in = ST_RWAIT;
         end
         ST_RWAIT: state_in = ST_RWRITE;
         ST_RWRITE: begin
            cmd.rec_write = 1'b1;
            state_in = ST_FADE;
         end
         ST_FADE: begin
            if (status.fade_needed) begin
               cmd.fade_start = 1'b1;
               count_in = CNT_BITS'(DIV_STEPS);
               state_in = ST_DIV;
            end else begin
               state_in = ST_MOD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in = count_ff - 1'b1;
            if (count_ff == CNT_BITS'(1)) state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_start = 1'b1;
            count_in = CNT_BITS'(MOD_STEPS);
            state_in = ST_MSTEP;
         end
         ST_MSTEP: begin
            cmd.mod_step = 1'b1;
            count_in = count_ff - 1'b1;
            if (count_ff == CNT_BITS'(1)) state_in = status.is_seek ? ST_SEEK : ST_FINISH;
         end
         ST_SEEK: begin
            cmd.seek = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         layer_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: hdl/llp_dp.sv
// Datapath: layer store, mix accumulator, fade divider and play pointer.
module llp_dp import llp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  llp_cmd_type                   cmd,
   input  llp_cmd_arg_type               arg,
   output llp_status_type                status,
   input  logic [1:0]                    req_mode,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic [LAYER_BITS-1:0]         req_layer_index,
   input  logic [POS_BITS-1:0]           req_position,
   input  logic [1:0]                    play_state,
   input  logic [LEN_BITS-1:0]           loop_length,
   input  logic [FADE_BITS-1:0]          crossfade_len,
   input  logic [SPEED_BITS-1:0]         speed,
   input  logic                          reversed,
   input  logic [7:0]                    layer_active,
   input  logic [2:0]                    record_layer,
   output logic                          result_load,
   output logic signed [OUT_BITS-1:0]    result_sample,
   output logic [POS_BITS-1:0]           result_position
);

   localparam int LEN_MAX = LOOP_DEPTH;

   logic signed [SAMPLE_BITS-1:0] store [0:LAYER_COUNT*LOOP_DEPTH-1];

   logic [1:0]                    mode_ff;
   logic signed [SAMPLE_BITS-1:0] samp_ff;
   logic [LAYER_BITS-1:0]         lidx_ff;
   logic [POS_BITS-1:0]           pos_ff;
   logic [POS_BITS-1:0]           ptr_ff;
   logic [7:0]                    frac_ff;
   logic [POS_BITS-1:0]           rpos_ff;
   logic [LEN_BITS-1:0]           len_ff;
   logic                          valid_ff;
   logic signed [SAMPLE_BITS-1:0] rdata_ff;
   logic signed [MIX_BITS-1:0]    mix_ff;
   logic                          neg_ff;
   logic [PROD_BITS-1:0]          quo_ff;
   logic [FADE_BITS:0]            rem_ff;
   logic signed [OUT_BITS-1:0]    res_ff;
   logic [LEN_BITS-1:0]           mq_ff;
   logic [LEN_BITS:0]             mr_ff;

   logic [LEN_BITS-1:0] len_eff;
   logic [LEN_BITS-1:0] ptr_ext;
   logic [LEN_BITS-1:0] rpos_calc;
   logic [LEN_BITS-1:0] end_gap;
   logic [SPEED_BITS-1:0] spd;
   logic [8+SPEED_BITS-1:0] fsum;
   logic [LEN_BITS-1:0] adv;
   logic [LEN_BITS:0]   mr_sh;
   logic [MIX_BITS-1:0] mag;
   logic [FADE_BITS-1:0] gain;
   logic [MIX_BITS+FADE_BITS-1:0] prod;
   logic [FADE_BITS:0]  rem_sh;
   logic signed [PROD_BITS:0] fade_val;

   // Effective loop length and read position.
   always_comb begin
      len_eff = loop_length;
      if (loop_length == '0) len_eff = LEN_BITS'(1);
      if (loop_length > LEN_BITS'(LEN_MAX)) len_eff = LEN_BITS'(LEN_MAX);
      ptr_ext = {1'b0, ptr_ff};
      rpos_calc = reversed ? (len_eff - 1'b1 - ptr_ext) : ptr_ext;
      end_gap = len_ff - 1'b1 - {1'b0, rpos_ff};
   end

   assign status.tick_live = (mode_ff == MODE_TICK) &&
                             (play_state == PS_PLAY || play_state == PS_RECORD);
   assign status.pos_valid = valid_ff;
   assign status.recording = (play_state == PS_RECORD);
   assign status.is_load = (mode_ff == MODE_LOAD);
   assign status.is_seek = (mode_ff == MODE_SEEK);
   assign status.active = layer_active[LAYER_COUNT-1:0];
   assign status.fade_needed = (crossfade_len != '0) &&
                               ({1'b0, len_ff} > {1'b0, crossfade_len, 1'b0}) &&
                               (({1'b0, rpos_ff} < {1'b0, crossfade_len}) ||
                                (end_gap < {1'b0, crossfade_len}));

   // Pointer advance with fraction carry, and one step of the wrap modulo the loop length.
   always_comb begin
      spd = speed;
      if (speed < SPEED_BITS'(64)) spd = SPEED_BITS'(64);
      if (speed > SPEED_BITS'(1024)) spd = SPEED_BITS'(1024);
      fsum = (8+SPEED_BITS)'(frac_ff) + (8+SPEED_BITS)'(spd);
      adv = LEN_BITS'(ptr_ff) + LEN_BITS'(fsum[8+SPEED_BITS-1:8]);
      mr_sh = {mr_ff[LEN_BITS-1:0], mq_ff[LEN_BITS-1]};
   end

   // Restoring divider step on the magnitude of mix times gain.
   always_comb begin
      mag = mix_ff[MIX_BITS-1] ? MIX_BITS'(-mix_ff) : MIX_BITS'(mix_ff);
      gain = ({1'b0, rpos_ff} < {1'b0, crossfade_len}) ? rpos_ff : end_gap[FADE_BITS-1:0];
      prod = (MIX_BITS+FADE_BITS)'(mag) * (MIX_BITS+FADE_BITS)'(gain);
      rem_sh = {rem_ff[FADE_BITS-1:0], quo_ff[PROD_BITS-1]};
      fade_val = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   end

   // Transaction, pointer and arithmetic registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         frac_ff <= '0;
      end else begin
         if (cmd.seek) begin
            ptr_ff <= mr_ff[POS_BITS-1:0];
            frac_ff <= '0;
         end else if (cmd.finish && status.tick_live) begin
            ptr_ff <= mr_ff[POS_BITS-1:0];
            frac_ff <= fsum[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff <= req_mode;
         samp_ff <= req_sample_in;
         lidx_ff <= req_layer_index;
         pos_ff <= req_position;
         len_ff <= len_eff;
         valid_ff <= ptr_ext < len_eff;
         rpos_ff <= (ptr_ext < len_eff) ? rpos_calc[POS_BITS-1:0] : '0;
         mix_ff <= '0;
      end
      if (cmd.acc) mix_ff <= mix_ff + MIX_BITS'(rdata_ff);
      if (cmd.fade_start) begin
         neg_ff <= mix_ff[MIX_BITS-1];
         quo_ff <= PROD_BITS'(prod);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= {1'b0, crossfade_len}) begin
            rem_ff <= rem_sh - {1'b0, crossfade_len};
            quo_ff <= {quo_ff[PROD_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[PROD_BITS-2:0], 1'b0};
         end
      end
      // Shift-and-subtract remainder of the seek target or advanced pointer.
      if (cmd.mod_start) begin
         mq_ff <= status.is_seek ? {1'b0, pos_ff} : adv;
         mr_ff <= '0;
      end
      if (cmd.mod_step) begin
         mq_ff <= {mq_ff[LEN_BITS-2:0], 1'b0};
         if (mr_sh >= {1'b0, len_ff}) begin
            mr_ff <= mr_sh - {1'b0, len_ff};
         end else begin
            mr_ff <= mr_sh;
         end
      end
      if (cmd.finish) begin
         if (!status.tick_live || !valid_ff) begin
            res_ff <= '0;
         end else if (status.fade_needed) begin
            res_ff <= OUT_BITS'(fade_val);
         end else begin
            res_ff <= OUT_BITS'(mix_ff);
         end
      end
   end

   // Layer store: one read or write port per cycle.
   always_ff @(posedge clock) begin
      if (cmd.load_write && (int'(lidx_ff) < LAYER_COUNT)) begin
         store[{lidx_ff, pos_ff}] <= samp_ff;
      end
      if (cmd.rec_write) begin
         store[{record_layer[LAYER_BITS-1:0], rpos_ff}] <=
            sat_sample((SAMPLE_BITS+2)'(rdata_ff) + (SAMPLE_BITS+2)'(samp_ff));
      end
      if (cmd.mem_read) rdata_ff <= store[{arg.layer, rpos_ff}];
      if (cmd.rec_read) rdata_ff <= store[{record_layer[LAYER_BITS-1:0], rpos_ff}];
   end

   // Result goes out in the cycle after finish, seek or load write.
   logic load_ff;
   always_ff @(posedge clock) begin
      if (reset) load_ff <= 1'b0;
      else load_ff <= cmd.finish || cmd.seek || cmd.load_write;
   end

   logic zero_ff;
   always_ff @(posedge clock) begin
      zero_ff <= cmd.seek || cmd.load_write;
   end

   assign result_load = load_ff;
   assign result_sample = zero_ff ? '0 : res_ff;
   assign result_position = ptr_ff;

endmodule

// File: hdl/looper_layer_playback.sv
// Top level of the looper layer playback block.
//
// Multi-layer looper: each request transaction is a sample tick, a load write or a
// seek, and returns one response transaction; only one transaction is in flight.
// A live tick walks the eight layers of the store one memory read at a time (a
// read and an accumulate state each), adds an overdub read-modify-write (read,
// wait and write states) in the recording state, runs a 44-step bit-serial fade
// divider inside the fade zones, and wraps the new pointer modulo the loop length
// with a 17-step remainder. A seek, or a tick whose pointer lies beyond the loop,
// goes straight to the wrap; a load write, an empty or muted tick or an unused
// mode goes straight to the response. The next request is taken in the cycle
// after the response is accepted. The single-port layer store sets the walk
// length. The store is not cleared at reset; entries must be loaded before use.
module looper_layer_playback import llp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   llp_req_if.sink                  req,
   llp_rsp_if.source                rsp,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   logic [1:0]            play_state_ff;
   logic [LEN_BITS-1:0]   loop_length_ff;
   logic [FADE_BITS-1:0]  crossfade_len_ff;
   logic [SPEED_BITS-1:0] speed_ff;
   logic                  reversed_ff;
   logic [7:0]            layer_active_ff;
   logic [2:0]            record_layer_ff;

   llp_cmd_type     cmd;
   llp_cmd_arg_type arg;
   llp_status_type  status;
   logic            result_load;
   logic signed [OUT_BITS-1:0] result_sample;
   logic [POS_BITS-1:0]        result_position;
   logic                       rsp_valid_ff;
   logic signed [OUT_BITS-1:0] rsp_sample_ff;
   logic [POS_BITS-1:0]        rsp_pos_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         play_state_ff <= PS_EMPTY;
         loop_length_ff <= LEN_BITS'(1);
         crossfade_len_ff <= '0;
         speed_ff <= SPEED_BITS'(256);
         reversed_ff <= 1'b0;
         layer_active_ff <= '0;
         record_layer_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PLAY_STATE:    play_state_ff <= csr_data[1:0];
            CSR_LOOP_LENGTH:   loop_length_ff <= csr_data[LEN_BITS-1:0];
            CSR_CROSSFADE_LEN: crossfade_len_ff <= csr_data[FADE_BITS-1:0];
            CSR_SPEED:         speed_ff <= csr_data[SPEED_BITS-1:0];
            CSR_REVERSED:      reversed_ff <= csr_data[0];
            CSR_LAYER_ACTIVE:  layer_active_ff <= csr_data[7:0];
            CSR_RECORD_LAYER:  record_layer_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // The controller stays busy while a response is loading or waiting.
   llp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_busy  (rsp_valid_ff || result_load),
      .status    (status),
      .cmd       (cmd),
      .arg       (arg)
   );

   llp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .arg             (arg),
      .status          (status),
      .req_mode        (req.mode),
      .req_sample_in   (req.sample_in),
      .req_layer_index (req.layer_index),
      .req_position    (req.position),
      .play_state      (play_state_ff),
      .loop_length     (loop_length_ff),
      .crossfade_len   (crossfade_len_ff),
      .speed           (speed_ff),
      .reversed        (reversed_ff),
      .layer_active    (layer_active_ff),
      .record_layer    (record_layer_ff),
      .result_load     (result_load),
      .result_sample   (result_sample),
      .result_position (result_position)
   );

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_sample_ff <= result_sample;
         rsp_pos_ff <= result_position;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.sample_out = rsp_sample_ff;
   assign rsp.play_position = rsp_pos_ff;

   // A new request is never taken while a response is pending.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("request taken while response pending");

   // A response is loaded only while none is waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result_load |-> !rsp_valid_ff) else $error("response overwritten");

   // The controller never issues more than one store read or write in the same cycle.
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.mem_read, cmd.rec_read, cmd.rec_write, cmd.load_write}) <= 1)
      else $error("store port conflict");

endmodule

// File: sim/llp_checker.sv
// Checker for the looper layer playback block: predicts every response and compares it.
`timescale 1ns / 1ps

module llp_checker import llp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   llp_req_if                       req,
   llp_rsp_if                       rsp,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output int                       errors,
   output int                       pending
);

   typedef struct {
      logic signed [OUT_BITS-1:0] smp;
      logic [POS_BITS-1:0]        pos;
   } playback_type;

   // Shadow copy of the layer store, indexed by {layer, position}.
   logic signed [SAMPLE_BITS-1:0] layer_mem [0:LAYER_COUNT*LOOP_DEPTH-1];
   playback_type                  playback_q[$];

   int unsigned pointer;
   int unsigned frac;
   logic [1:0]  state_r;
   int unsigned length_r;
   int unsigned fade_r;
   int unsigned speed_r;
   logic        reverse_r;
   logic [7:0]  active_r;
   logic [2:0]  rec_r;

   function automatic logic signed [SAMPLE_BITS-1:0] clamp24(input longint v);
      if (v > 64'sd8388607) return 24'sd8388607;
      if (v < -64'sd8388608) return -24'sd8388608;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Computes the response of one request and updates the shadow state.
   task automatic play_request(input logic [1:0] mode, input logic signed [23:0] smp,
                               input logic [2:0] lay, input logic [15:0] pos,
                               output playback_type res);
      int unsigned len_eff;
      int unsigned rpos;
      int unsigned end_gap;
      int unsigned spd;
      int unsigned sum;
      longint      mix;
      longint      scaled;
      int unsigned addr;
      len_eff = (length_r == 0) ? 1 : ((length_r > LOOP_DEPTH) ? LOOP_DEPTH : length_r);
      scaled  = 0;
      if (mode == MODE_TICK) begin
         if (state_r == PS_PLAY || state_r == PS_RECORD) begin
            mix  = 0;
            rpos = 0;
            if (pointer < len_eff) begin
               rpos = reverse_r ? (len_eff - 1 - pointer) : pointer;
               for (int i = 0; i < LAYER_COUNT; i++)
                  if (active_r[i]) mix += layer_mem[i*LOOP_DEPTH + rpos];
               // Overdub lands after the mix is taken, so it is heard next pass.
               if (state_r == PS_RECORD) begin
                  addr = rec_r * LOOP_DEPTH + rpos;
                  layer_mem[addr] = clamp24(longint'(layer_mem[addr]) + smp);
               end
            end
            scaled = mix;
            if (fade_r != 0 && len_eff > 2 * fade_r) begin
               end_gap = len_eff - 1 - rpos;
               if (rpos < fade_r) scaled = (mix * longint'(rpos)) / longint'(fade_r);
               else if (end_gap < fade_r)
                  scaled = (mix * longint'(end_gap)) / longint'(fade_r);
            end
            if (scaled > 64'sd67108863) scaled = 64'sd67108863;
            if (scaled < -64'sd67108864) scaled = -64'sd67108864;
            spd = (speed_r < 64) ? 64 : ((speed_r > 1024) ? 1024 : speed_r);
            sum = frac + spd;
            frac = sum & 8'hFF;
            pointer = (pointer + (sum >> 8)) % len_eff;
         end
      end else if (mode == MODE_LOAD) begin
         layer_mem[{lay, pos}] = smp;
      end else if (mode == MODE_SEEK) begin
         pointer = pos % len_eff;
         frac = 0;
      end
      res.smp = scaled[OUT_BITS-1:0];
      res.pos = pointer[POS_BITS-1:0];
   endtask

   always @(posedge clock) begin
      playback_type exp_r;
      playback_type got;
      int           delta;
      if (reset) begin
         pointer   = 0;
         frac      = 0;
         state_r   = PS_EMPTY;
         length_r  = 1;
         fade_r    = 0;
         speed_r   = 256;
         reverse_r = 0;
         active_r  = 0;
         rec_r     = 0;
         playback_q.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         delta = 0;
         // Register writes.
         if (csr_write) begin
            case (csr_index)
               CSR_PLAY_STATE:    state_r   = csr_data[1:0];
               CSR_LOOP_LENGTH:   length_r  = csr_data;
               CSR_CROSSFADE_LEN: fade_r    = csr_data[15:0];
               CSR_SPEED:         speed_r   = csr_data[10:0];
               CSR_REVERSED:      reverse_r = csr_data[0];
               CSR_LAYER_ACTIVE:  active_r  = csr_data[7:0];
               CSR_RECORD_LAYER:  rec_r     = csr_data[2:0];
               default: ;
            endcase
         end
         // Compare a response transaction with the oldest expectation.
         if (rsp.valid && rsp.ready) begin
            got.smp = rsp.sample_out;
            got.pos = rsp.play_position;
            if (playback_q.size() == 0) begin
               $display("%0t unexpected response: sample_out %0d play_position %0d",
                        $time, got.smp, got.pos);
               errors <= errors + 1;
            end else begin
               exp_r = playback_q.pop_front();
               delta = delta - 1;
               if (exp_r.smp !== got.smp || exp_r.pos !== got.pos) begin
                  $display({"%0t mismatch: sample_out expected %0d got %0d,",
                            " play_position expected %0d got %0d"},
                           $time, exp_r.smp, got.smp, exp_r.pos, got.pos);
                  errors <= errors + 1;
               end
            end
         end
         // Predict a request transaction.
         if (req.valid && req.ready) begin
            play_request(req.mode, req.sample_in, req.layer_index, req.position, exp_r);
            playback_q.insert(playback_q.size(), exp_r);
            delta = delta + 1;
         end
         pending <= pending + delta;
      end
   end

endmodule

// File: sim/tb.sv
// Testbench top for the looper layer playback block: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb;
   import llp_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int ITEM_GOAL   = 1150;

   logic                     clock;
   logic                     reset;
   logic                     csr_write;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;
   int                       errors;
   int                       pending;

   llp_req_if req ();
   llp_rsp_if rsp ();

   looper_layer_playback dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   llp_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending)
   );

   // Store entries that have been loaded; ticks only read these.
   bit written [0:LAYER_COUNT*LOOP_DEPTH-1];
   bit calm;
   bit hold_rsp;
   int items_sent;
   int responses;
   int setups;
   int quiet;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else begin
            rsp.ready <= calm || ($urandom_range(99) >= 26);
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (rsp.valid && rsp.ready) responses <= responses + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offers one request transaction and returns at the edge that accepts it.
   task automatic send(input logic [1:0] mode, input logic signed [23:0] smp,
                       input logic [2:0] lay, input logic [15:0] pos);
      bit taken;
      while (!calm && $urandom_range(99) < 26) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.mode        <= mode;
      req.sample_in   <= smp;
      req.layer_index <= lay;
      req.position    <= pos;
      do begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end while (!taken);
      if (mode == MODE_LOAD) written[{lay, pos}] = 1;
      items_sent++;
   endtask

   function automatic logic signed [23:0] pick_sample();
      case ($urandom_range(7))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         default: return 24'($urandom());
      endcase
   endfunction

   // Loads every unwritten position of a window in the given layers.
   task automatic fill(input logic [7:0] layers, input int first, input int count);
      int p;
      for (int l = 0; l < LAYER_COUNT; l++)
         if (layers[l])
            for (int k = 0; k < count; k++) begin
               p = (first + k) % LOOP_DEPTH;
               if (!written[l*LOOP_DEPTH + p])
                  send(MODE_LOAD, pick_sample(), 3'(l), 16'(p));
            end
   endtask

   // Lets the block drain, then writes all registers back to back.
   task automatic configure(input logic [1:0] st, input logic [16:0] len,
                            input logic [15:0] fade, input logic [10:0] spd,
                            input logic rev, input logic [7:0] act, input logic [2:0] rec);
      logic [16:0] vals [0:6];
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      vals = '{17'(st), len, 17'(fade), 17'(spd), 17'(rev), 17'(act), 17'(rec)};
      for (int i = 0; i < 7; i++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_IDX_BITS'(i);
         csr_data  <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      setups++;
   endtask

   initial begin
      logic [1:0]  st;
      logic [16:0] len;
      int          eff;
      logic [7:0]  act;
      logic [2:0]  rec;
      logic [15:0] fade;
      logic [10:0] spd;
      int          n;
      int          r;
      int          phase;
      clock = 1'b0;
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      req.valid <= 1'b0;
      req.mode <= MODE_TICK;
      req.sample_in <= '0;
      req.layer_index <= '0;
      req.position <= '0;
      calm = 0;
      hold_rsp = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme data in two layers, wrap, seek past the loop, unused mode.
      configure(PS_PLAY, 17'd4, 16'd0, 11'd256, 1'b0, 8'h81, 3'd7);
      send(MODE_LOAD, 24'sh7FFFFF, 3'd0, 16'd0);
      send(MODE_LOAD, 24'sh800000, 3'd0, 16'd1);
      send(MODE_LOAD, 24'sd1, 3'd0, 16'd2);
      send(MODE_LOAD, -24'sd1, 3'd0, 16'd3);
      fill(8'h80, 0, 4);
      send(MODE_LOAD, 24'sh800000, 3'd7, 16'hFFFF);
      repeat (5) send(MODE_TICK, 24'sd0, 3'd0, 16'd0);
      send(MODE_SEEK, 24'sd0, 3'd0, 16'hFFFF);
      send(MODE_UNUSED, 24'sh7FFFFF, 3'd7, 16'hFFFF);
      send(MODE_TICK, 24'sd0, 3'd0, 16'd0);
      // Overdub saturation, reversed play, muted state.
      configure(PS_RECORD, 17'd4, 16'd0, 11'd256, 1'b1, 8'h81, 3'd7);
      repeat (3) send(MODE_TICK, 24'sh7FFFFF, 3'd0, 16'd0);
      configure(PS_MUTED, 17'd4, 16'd1, 11'd0, 1'b0, 8'hFF, 3'd0);
      send(MODE_TICK, 24'sd5, 3'd0, 16'd0);
      send(MODE_SEEK, 24'sd0, 3'd0, 16'd2);

      // Random phases with small loops, and long loop phases near the wrap point.
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         calm = (phase == 2);
         if (phase == 5 || phase == 11) begin
            // Long loop: stay in a loaded window around the wrap point.
            act = 8'h81;
            rec = 3'd7;
            configure(phase == 5 ? PS_RECORD : PS_PLAY, phase == 5 ? 17'd65536 : 17'h1FFFF,
                      phase == 5 ? 16'd32767 : 16'hFFFF, 11'd1024, phase == 11, act, rec);
            fill(act, 65496, 80);
            send(MODE_SEEK, 24'sd0, 3'd0, 16'd65520);
            repeat (10) send(MODE_TICK, pick_sample(), 3'd0, 16'd0);
         end else begin
            r   = $urandom_range(9);
            st  = (r < 4) ? PS_PLAY : ((r < 8) ? PS_RECORD : ((r == 8) ? PS_MUTED : PS_EMPTY));
            r   = $urandom_range(19);
            len = (r == 0) ? 17'd0 : ((r < 6) ? 17'($urandom_range(1, 4))
                                              : 17'($urandom_range(5, 40)));
            eff = (len == 0) ? 1 : int'(len);
            r   = $urandom_range(9);
            fade = (r < 2) ? 16'd0 : ((r == 2) ? 16'($urandom()) : 16'($urandom_range(1, 20)));
            r   = $urandom_range(9);
            spd = (r == 0) ? 11'd0 : ((r == 1) ? 11'd2047 :
                  ((r == 2) ? 11'd64 : ((r == 3) ? 11'd1024 : 11'($urandom_range(64, 1024)))));
            act = 8'($urandom());
            rec = 3'($urandom());
            configure(st, len, fade, spd, 1'($urandom_range(1)), act, rec);
            fill(act | (8'h1 << rec), 0, eff);
            if (phase == 3) hold_rsp = 1;
            n = $urandom_range(20, 60);
            repeat (n) begin
               r = $urandom_range(99);
               if (r < 80)
                  send(MODE_TICK, pick_sample(), 3'($urandom()), 16'($urandom()));
               else if (r < 88)
                  send(MODE_LOAD, pick_sample(), 3'($urandom()), 16'($urandom()));
               else if (r < 96)
                  send(MODE_SEEK, pick_sample(), 3'($urandom()), 16'($urandom()));
               else
                  send(MODE_UNUSED, pick_sample(), 3'($urandom()), 16'($urandom()));
            end
         end
         phase++;
      end

      // Drain and settle.
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Run covered %0d request transactions and %0d responses over %0d setups,",
               items_sent, responses, setups);
      $display("including overdub, reversed play, fades, seeks and a long response hold-off.");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: looper_layer_playback.f
hdl/llp_pkg.sv
hdl/llp_if.sv
hdl/llp_ctrl.sv
hdl/llp_dp.sv
hdl/looper_layer_playback.sv
sim/llp_checker.sv
sim/tb.sv
